// ----- rtl/rstg_pkg.sv -----
`default_nettype none

package rstg_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_UPDATE = 2'd1,
        OP_PITCH  = 2'd2,
        OP_RATE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_VOLUME = 2'd0,
        REG_LENGTH = 2'd1,
        REG_ENABLE = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        LVL_KEEP,
        LVL_MID,
        LVL_SINE
    } level_op_t;

    // What the second stage needs to finish a word.
    typedef struct packed {
        level_op_t  level_op;
        logic       is_pitch;
        logic [7:0] frac;
        logic       running;
    } stage_t;

    localparam logic [15:0] DEFAULT_STEP   = 16'd461;
    localparam logic [15:0] DEFAULT_LENGTH = 16'd7812;
    localparam logic [15:0] PITCH_MAX      = 16'd65279;
    localparam logic [7:0]  MID_LEVEL      = 8'd128;

    localparam logic [7:0] SINE_TABLE [256] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd153, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
        8'd177, 8'd180, 8'd182, 8'd185, 8'd188, 8'd191, 8'd194, 8'd196,
        8'd199, 8'd201, 8'd204, 8'd207, 8'd209, 8'd211, 8'd214, 8'd216,
        8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231, 8'd232,
        8'd234, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd243, 8'd245,
        8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253,
        8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253,
        8'd253, 8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
        8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
        8'd233, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd192, 8'd189, 8'd187, 8'd184, 8'd181, 8'd178,
        8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
        8'd151, 8'd148, 8'd145, 8'd142, 8'd139, 8'd135, 8'd132, 8'd129,
        8'd126, 8'd123, 8'd120, 8'd116, 8'd113, 8'd110, 8'd107, 8'd104,
        8'd101, 8'd98,  8'd95,  8'd92,  8'd89,  8'd86,  8'd83,  8'd80,
        8'd77,  8'd74,  8'd71,  8'd68,  8'd66,  8'd63,  8'd60,  8'd57,
        8'd55,  8'd52,  8'd50,  8'd47,  8'd45,  8'd42,  8'd40,  8'd38,
        8'd36,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,  8'd22,
        8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,  8'd10,
        8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd4,   8'd3,   8'd2,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
        8'd10,  8'd12,  8'd13,  8'd14,  8'd16,  8'd17,  8'd19,  8'd21,
        8'd23,  8'd24,  8'd26,  8'd28,  8'd30,  8'd32,  8'd35,  8'd37,
        8'd39,  8'd41,  8'd44,  8'd46,  8'd48,  8'd51,  8'd54,  8'd56,
        8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd73,  8'd75,  8'd78,
        8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,  8'd102,
        8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124, 8'd128
    };

    localparam logic [11:0] STEP_TABLE [256] = '{
        12'd461,  12'd474,  12'd486,  12'd499,  12'd512,  12'd524,  12'd537,  12'd550,
        12'd562,  12'd575,  12'd588,  12'd600,  12'd613,  12'd626,  12'd638,  12'd651,
        12'd664,  12'd676,  12'd689,  12'd702,  12'd714,  12'd727,  12'd740,  12'd752,
        12'd765,  12'd778,  12'd790,  12'd803,  12'd815,  12'd828,  12'd841,  12'd853,
        12'd866,  12'd879,  12'd891,  12'd904,  12'd917,  12'd929,  12'd942,  12'd955,
        12'd967,  12'd980,  12'd993,  12'd1005, 12'd1018, 12'd1031, 12'd1043, 12'd1056,
        12'd1069, 12'd1081, 12'd1094, 12'd1107, 12'd1119, 12'd1132, 12'd1145, 12'd1157,
        12'd1170, 12'd1183, 12'd1195, 12'd1208, 12'd1221, 12'd1233, 12'd1246, 12'd1259,
        12'd1271, 12'd1284, 12'd1297, 12'd1309, 12'd1322, 12'd1335, 12'd1347, 12'd1360,
        12'd1373, 12'd1385, 12'd1398, 12'd1411, 12'd1423, 12'd1436, 12'd1449, 12'd1461,
        12'd1474, 12'd1487, 12'd1499, 12'd1512, 12'd1525, 12'd1537, 12'd1550, 12'd1563,
        12'd1575, 12'd1588, 12'd1601, 12'd1613, 12'd1626, 12'd1639, 12'd1651, 12'd1664,
        12'd1677, 12'd1689, 12'd1702, 12'd1715, 12'd1727, 12'd1740, 12'd1753, 12'd1765,
        12'd1778, 12'd1791, 12'd1803, 12'd1816, 12'd1829, 12'd1841, 12'd1854, 12'd1867,
        12'd1879, 12'd1892, 12'd1905, 12'd1917, 12'd1930, 12'd1943, 12'd1955, 12'd1968,
        12'd1981, 12'd1993, 12'd2006, 12'd2019, 12'd2031, 12'd2044, 12'd2057, 12'd2069,
        12'd2082, 12'd2095, 12'd2107, 12'd2120, 12'd2133, 12'd2145, 12'd2158, 12'd2171,
        12'd2183, 12'd2196, 12'd2209, 12'd2221, 12'd2234, 12'd2247, 12'd2259, 12'd2272,
        12'd2285, 12'd2297, 12'd2310, 12'd2323, 12'd2335, 12'd2348, 12'd2361, 12'd2373,
        12'd2386, 12'd2399, 12'd2411, 12'd2424, 12'd2437, 12'd2449, 12'd2462, 12'd2475,
        12'd2487, 12'd2500, 12'd2513, 12'd2525, 12'd2538, 12'd2551, 12'd2563, 12'd2576,
        12'd2589, 12'd2601, 12'd2614, 12'd2627, 12'd2639, 12'd2652, 12'd2665, 12'd2677,
        12'd2690, 12'd2703, 12'd2715, 12'd2728, 12'd2741, 12'd2753, 12'd2766, 12'd2779,
        12'd2791, 12'd2804, 12'd2817, 12'd2829, 12'd2842, 12'd2855, 12'd2867, 12'd2880,
        12'd2893, 12'd2905, 12'd2918, 12'd2931, 12'd2943, 12'd2956, 12'd2969, 12'd2981,
        12'd2994, 12'd3007, 12'd3019, 12'd3032, 12'd3045, 12'd3057, 12'd3070, 12'd3083,
        12'd3095, 12'd3108, 12'd3121, 12'd3133, 12'd3146, 12'd3159, 12'd3171, 12'd3184,
        12'd3197, 12'd3209, 12'd3222, 12'd3235, 12'd3247, 12'd3260, 12'd3273, 12'd3285,
        12'd3298, 12'd3311, 12'd3323, 12'd3336, 12'd3349, 12'd3361, 12'd3374, 12'd3387,
        12'd3399, 12'd3412, 12'd3425, 12'd3437, 12'd3450, 12'd3463, 12'd3475, 12'd3488,
        12'd3501, 12'd3513, 12'd3526, 12'd3539, 12'd3551, 12'd3564, 12'd3577, 12'd3589,
        12'd3602, 12'd3614, 12'd3627, 12'd3640, 12'd3652, 12'd3665, 12'd3678, 12'd3690
    };

endpackage

`default_nettype wire

// ----- rtl/rstg_sine_rom.sv -----
`default_nettype none

// Sine table with a registered read port.
module rstg_sine_rom (
    input  wire logic       clk,
    input  wire logic       rd_en,
    input  wire logic [7:0] addr,
    output logic      [7:0] data
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= rstg_pkg::SINE_TABLE[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- rtl/rstg_step_rom.sv -----
`default_nettype none

// Step table with two registered read ports, one for each interpolation end.
module rstg_step_rom (
    input  wire logic        clk,
    input  wire logic        rd_en,
    input  wire logic [7:0]  addr_a,
    input  wire logic [7:0]  addr_b,
    output logic      [11:0] data_a,
    output logic      [11:0] data_b
);

    logic [11:0] data_a_reg;
    logic [11:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= rstg_pkg::STEP_TABLE[addr_a];
            data_b_reg <= rstg_pkg::STEP_TABLE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire

// ----- rtl/rstg_ctrl.sv -----
`default_nettype none

// First stage: tone sequencing state, updated as each word is accepted.
module rstg_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [1:0]     opcode,
    input  wire logic [15:0]    operand,
    input  wire logic [15:0]    length_limit,
    input  wire logic           enable,
    input  wire logic           pitch_wr,
    input  wire logic [15:0]    pitch_step,
    output logic      [7:0]     sine_addr,
    output logic      [7:0]     step_addr_lo,
    output logic      [7:0]     step_addr_hi,
    output rstg_pkg::stage_t    stage
);

    logic [15:0] phase_reg;
    logic [15:0] phase_next;
    logic [15:0] phase_step_reg;
    logic [15:0] phase_step_next;
    logic [15:0] pending_step_reg;
    logic [15:0] repeat_rate_reg;
    logic [15:0] repeat_rate_next;
    logic [15:0] sample_count_reg;
    logic [15:0] sample_count_next;
    logic [15:0] rate_acc_reg;
    logic [15:0] rate_acc_next;
    logic        running_reg;
    logic        running_next;
    logic [15:0] pending_fwd;
    logic [15:0] count_inc;
    logic [15:0] pitch_index;
    logic        trigger;

    // A pitch result finishing in the second stage this cycle wins.
    assign pending_fwd = pitch_wr ? pitch_step : pending_step_reg;
    assign count_inc   = sample_count_reg + 16'd1;
    assign trigger     = (16'd0 - rate_acc_reg) < repeat_rate_reg;
    assign pitch_index = (operand > rstg_pkg::PITCH_MAX) ? rstg_pkg::PITCH_MAX : operand;

    assign sine_addr    = phase_reg[15:8];
    assign step_addr_lo = pitch_index[15:8];
    assign step_addr_hi = pitch_index[15:8] + 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        phase_step_next   = phase_step_reg;
        repeat_rate_next  = repeat_rate_reg;
        sample_count_next = sample_count_reg;
        rate_acc_next     = rate_acc_reg;
        running_next      = running_reg;
        stage.level_op    = rstg_pkg::LVL_KEEP;
        stage.is_pitch    = 1'b0;
        stage.frac        = pitch_index[7:0];
        unique case (rstg_pkg::opcode_t'(opcode))
            rstg_pkg::OP_SAMPLE:
            begin
                if (running_reg)
                begin
                    sample_count_next = count_inc;
                    if (count_inc < length_limit)
                    begin
                        phase_next     = phase_reg + phase_step_reg;
                        stage.level_op = rstg_pkg::LVL_SINE;
                    end
                    else
                    begin
                        running_next = 1'b0;
                        phase_next   = 16'd0;
                    end
                end
            end
            rstg_pkg::OP_UPDATE:
            begin
                if (enable)
                begin
                    if (trigger)
                    begin
                        phase_step_next   = pending_fwd;
                        sample_count_next = 16'd0;
                        if (!running_reg)
                        begin
                            running_next   = 1'b1;
                            stage.level_op = rstg_pkg::LVL_MID;
                        end
                    end
                    rate_acc_next = rate_acc_reg + repeat_rate_reg;
                end
            end
            rstg_pkg::OP_PITCH:
            begin
                stage.is_pitch = 1'b1;
            end
            rstg_pkg::OP_RATE:
            begin
                repeat_rate_next = operand;
            end
            default:
            begin
                stage.is_pitch = 1'b0;
            end
        endcase
        stage.running = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= 16'd0;
            phase_step_reg   <= rstg_pkg::DEFAULT_STEP;
            pending_step_reg <= rstg_pkg::DEFAULT_STEP;
            repeat_rate_reg  <= 16'd0;
            sample_count_reg <= 16'd0;
            rate_acc_reg     <= 16'd0;
            running_reg      <= 1'b0;
        end
        else
        begin
            if (pitch_wr)
            begin
                pending_step_reg <= pitch_step;
            end
            if (accept)
            begin
                phase_reg        <= phase_next;
                phase_step_reg   <= phase_step_next;
                repeat_rate_reg  <= repeat_rate_next;
                sample_count_reg <= sample_count_next;
                rate_acc_reg     <= rate_acc_next;
                running_reg      <= running_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/retriggered_sine_tone_generator.sv -----
`default_nettype none

// Retriggered sine tone generator. One word is accepted on every clock
// cycle while in_stall is low; each word gives exactly one result word,
// which passes from the second-stage register into the output register
// and is held there while out_stall is high. The stages follow the
// registered read of the sine and step tables: the first stage updates
// the phase, tone counter and repetition accumulator and addresses the
// tables, the second stage scales the sine sample by the volume shift,
// interpolates a new pitch step and writes the PWM level. The output
// register and the second stage together let one more word in while a
// result is stalled. Configuration writes (volume shift, tone length, enable) must be made
// while no word is in flight.
module retriggered_sine_tone_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] operand,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  pwm_level,
    output logic             tone_active,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [3:0]  volume_reg;
    logic [15:0] length_reg;
    logic        enable_reg;

    logic              accept;
    logic              s1_move;
    logic              s1_valid_reg;
    rstg_pkg::stage_t  s1_reg;
    rstg_pkg::stage_t  stage;

    logic [7:0]  sine_addr;
    logic [7:0]  step_addr_lo;
    logic [7:0]  step_addr_hi;
    logic [7:0]  sine_data;
    logic [11:0] step_lo;
    logic [11:0] step_hi;

    logic        pitch_wr;
    logic [15:0] pitch_step;
    logic [19:0] interp_prod;
    logic [7:0]  scaled_level;
    logic [7:0]  level_reg;
    logic [7:0]  level_next;

    logic        out_valid_reg;
    logic [7:0]  pwm_level_reg;
    logic        tone_active_reg;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= 4'd0;
            length_reg <= rstg_pkg::DEFAULT_LENGTH;
            enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rstg_pkg::REG_VOLUME: volume_reg <= cfg_data[3:0];
                rstg_pkg::REG_LENGTH: length_reg <= cfg_data;
                rstg_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                default:              enable_reg <= enable_reg;
            endcase
        end
    end

    // The second stage moves on whenever the output register is free or
    // being emptied; a new word may enter whenever the second stage moves
    // or is empty.
    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    rstg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (opcode),
        .operand      (operand),
        .length_limit (length_reg),
        .enable       (enable_reg),
        .pitch_wr     (pitch_wr),
        .pitch_step   (pitch_step),
        .sine_addr    (sine_addr),
        .step_addr_lo (step_addr_lo),
        .step_addr_hi (step_addr_hi),
        .stage        (stage)
    );

    rstg_sine_rom u_sine_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (sine_addr),
        .data  (sine_data)
    );

    rstg_step_rom u_step_rom (
        .clk    (clk),
        .rd_en  (accept),
        .addr_a (step_addr_lo),
        .addr_b (step_addr_hi),
        .data_a (step_lo),
        .data_b (step_hi)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_move || !s1_valid_reg)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
    end

    // The step table rises monotonically, so the difference is never negative.
    assign interp_prod = 20'(step_hi - step_lo) * 20'(s1_reg.frac);
    assign pitch_step  = 16'(step_lo) + 16'(interp_prod[19:8]);
    assign pitch_wr    = s1_valid_reg && s1_move && s1_reg.is_pitch;

    // Level pulled toward the midpoint; shifts of eight or more leave 128.
    assign scaled_level = rstg_pkg::MID_LEVEL - (rstg_pkg::MID_LEVEL >> volume_reg)
                          + (sine_data >> volume_reg);

    always_comb
    begin
        case (s1_reg.level_op)
            rstg_pkg::LVL_MID:  level_next = rstg_pkg::MID_LEVEL;
            rstg_pkg::LVL_SINE: level_next = scaled_level;
            default:            level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            pwm_level_reg   <= level_next;
            tone_active_reg <= s1_reg.running;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_level   = pwm_level_reg;
    assign tone_active = tone_active_reg;

endmodule

`default_nettype wire
